### sv/dmx_frame_transmitter_unit_defines.svh
//------------------------------------------------------------------------------
// dmx frame transmitter assertion macros
// shared assertion forms for the dmx frame transmitter
//------------------------------------------------------------------------------
`ifndef DMX_FRAME_TRANSMITTER_UNIT_DEFINES_SVH
`define DMX_FRAME_TRANSMITTER_UNIT_DEFINES_SVH

// same-cycle implication
`define DMX_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dmx same-cycle check failed");

// next-cycle implication
`define DMX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dmx next-cycle check failed");

`endif

### sv/dmx_pkg.sv
//------------------------------------------------------------------------------
// dmx_pkg
// types and constants of the dmx frame transmitter
//------------------------------------------------------------------------------
package dmx_pkg;

    localparam int OP_W        = 2;
    localparam int CHAN_W      = 9;
    localparam int LEVEL_W     = 8;
    localparam int PHASE_W     = 2;
    localparam int TICK_W      = 16;
    localparam int INDEX_W     = 10;
    localparam int DATA_W      = 32;
    localparam int PADDR_W     = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic [TICK_W-1:0] RST_BREAK_TICKS = 16'd100;
    localparam logic [TICK_W-1:0] RST_MAB_TICKS   = 16'd12;
    localparam logic [TICK_W-1:0] RST_MBB_TICKS   = 16'd10;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE,
        OP_TICK,
        OP_BYTE_REQ,
        OP_TX_DONE
    } op_t;

    typedef enum logic [PHASE_W-1:0] {
        PH_MBB,
        PH_BREAK,
        PH_MAB,
        PH_DATA
    } phase_t;

    typedef enum logic [1:0] {
        REG_BREAK,
        REG_MAB,
        REG_MBB
    } reg_idx_t;

    typedef struct packed {
        logic [TICK_W-1:0] break_ticks;
        logic [TICK_W-1:0] mab_ticks;
        logic [TICK_W-1:0] mbb_ticks;
    } cfg_t;

    typedef struct packed {
        op_t                op;
        logic [CHAN_W-1:0]  channel;
        logic [LEVEL_W-1:0] level;
        logic               write_ok;
    } cmd_t;

endpackage

### sv/dmx_evt_if.sv
//------------------------------------------------------------------------------
// dmx_evt_if
// event channel: channel writes, ticks, byte requests, transmit complete
//------------------------------------------------------------------------------
interface dmx_evt_if;
    import dmx_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [CHAN_W-1:0]  channel;
    logic [LEVEL_W-1:0] level;

    modport source (output valid, op, channel, level, input ready);
    modport sink   (input valid, op, channel, level, output ready);
endinterface

### sv/dmx_res_if.sv
//------------------------------------------------------------------------------
// dmx_res_if
// result channel: line state and serializer byte for each event
//------------------------------------------------------------------------------
interface dmx_res_if;
    import dmx_pkg::*;

    logic               valid;
    logic               ready;
    logic               line_high;
    logic               serializer_on;
    logic [PHASE_W-1:0] phase;
    logic               byte_valid;
    logic [LEVEL_W-1:0] byte_out;
    logic               last_byte;
    logic               write_ok;

    modport source (
        output valid, line_high, serializer_on, phase, byte_valid, byte_out, last_byte,
               write_ok,
        input  ready
    );
    modport sink (
        input  valid, line_high, serializer_on, phase, byte_valid, byte_out, last_byte,
               write_ok,
        output ready
    );
endinterface

### sv/dmx_cfg_regs.sv
//------------------------------------------------------------------------------
// dmx_cfg_regs
// apb register file holding the three phase lengths
//------------------------------------------------------------------------------
module dmx_cfg_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dmx_pkg::PADDR_W-1:0]  paddr,
    input  logic [dmx_pkg::DATA_W-1:0]   pwdata,
    output logic [dmx_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output dmx_pkg::cfg_t                cfg
);
    import dmx_pkg::*;

    logic [TICK_W-1:0] break_ticks_reg;
    logic [TICK_W-1:0] mab_ticks_reg;
    logic [TICK_W-1:0] mbb_ticks_reg;
    logic [1:0]        reg_sel;
    logic              wr_en;

    assign reg_sel = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            break_ticks_reg <= RST_BREAK_TICKS;
            mab_ticks_reg   <= RST_MAB_TICKS;
            mbb_ticks_reg   <= RST_MBB_TICKS;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_BREAK: break_ticks_reg <= pwdata[TICK_W-1:0];
                REG_MAB:   mab_ticks_reg   <= pwdata[TICK_W-1:0];
                REG_MBB:   mbb_ticks_reg   <= pwdata[TICK_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_BREAK: prdata = DATA_W'(break_ticks_reg);
            REG_MAB:   prdata = DATA_W'(mab_ticks_reg);
            REG_MBB:   prdata = DATA_W'(mbb_ticks_reg);
            default:   prdata = '0;
        endcase
    end

    assign cfg.break_ticks = break_ticks_reg;
    assign cfg.mab_ticks   = mab_ticks_reg;
    assign cfg.mbb_ticks   = mbb_ticks_reg;
endmodule

### sv/dmx_front.sv
//------------------------------------------------------------------------------
// dmx_front
// accepts events and classifies them into commands for the queue
//------------------------------------------------------------------------------
module dmx_front #(
    parameter int CHANNEL_COUNT = 512
) (
    input  logic          clear_busy,
    input  logic          q_full,
    dmx_evt_if.sink       evt,
    output logic          push,
    output dmx_pkg::cmd_t push_cmd
);
    import dmx_pkg::*;

    localparam int CMP_W = CHAN_W + 1;

    logic in_range;

    // no events while the channel store is being cleared
    assign evt.ready = !q_full && !clear_busy;
    assign push      = evt.valid && evt.ready;

    assign in_range = {1'b0, evt.channel} < CMP_W'(CHANNEL_COUNT);

    always_comb
    begin
        push_cmd.op       = op_t'(evt.op);
        push_cmd.channel  = evt.channel;
        push_cmd.level    = evt.level;
        push_cmd.write_ok = (op_t'(evt.op) == OP_WRITE) && in_range;
    end
endmodule

### sv/dmx_cmd_queue.sv
//------------------------------------------------------------------------------
// dmx_cmd_queue
// short command queue between front and back
//------------------------------------------------------------------------------
module dmx_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  dmx_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          q_valid,
    output dmx_pkg::cmd_t q_cmd
);
    import dmx_pkg::*;

    localparam int CNT_W = QPTR_W + 1;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_pop;

    assign full    = count_reg == CNT_W'(QUEUE_DEPTH);
    assign q_valid = count_reg != '0;
    assign q_cmd   = entry_reg[rd_ptr_reg];
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        count_next = count_reg;
        case ({push, do_pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end
endmodule

### sv/dmx_back.sv
//------------------------------------------------------------------------------
// dmx_back
// frame sequencer: channel store, phase machine and result register
//------------------------------------------------------------------------------
module dmx_back #(
    parameter int CHANNEL_COUNT = 512
) (
    input  logic          clk,
    input  logic          rst_n,
    input  dmx_pkg::cfg_t cfg,
    input  logic          q_valid,
    input  dmx_pkg::cmd_t q_cmd,
    output logic          pop,
    output logic          clear_busy,
    dmx_res_if.source     res
);
    import dmx_pkg::*;

    localparam int AW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

    logic [LEVEL_W-1:0] store_mem [CHANNEL_COUNT];
    logic [LEVEL_W-1:0] rd_data_reg;

    logic               clr_busy_reg;
    logic [AW-1:0]      clr_idx_reg;

    phase_t             phase_reg;
    phase_t             phase_next;
    logic [TICK_W-1:0]  ticks_left_reg;
    logic [TICK_W-1:0]  ticks_left_next;
    logic [INDEX_W-1:0] byte_index_reg;
    logic [INDEX_W-1:0] byte_index_next;
    logic               all_sent_reg;
    logic               all_sent_next;

    logic               res_valid_reg;
    phase_t             res_phase_reg;
    logic               res_byte_valid_reg;
    logic               res_use_mem_reg;
    logic               res_last_reg;
    logic               res_write_ok_reg;

    logic               exec;
    logic               byte_valid;
    logic               use_mem;
    logic               last_byte;
    logic [INDEX_W-1:0] rd_index;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;

    function automatic logic [TICK_W-1:0] load_len(input logic [TICK_W-1:0] len);
        return (len == '0) ? TICK_W'(1) : len;
    endfunction

    assign exec       = q_valid && !clr_busy_reg && (!res_valid_reg || res.ready);
    assign pop        = exec;
    assign clear_busy = clr_busy_reg;

    assign rd_index = byte_index_reg - INDEX_W'(1);
    assign rd_addr  = rd_index[AW-1:0];
    assign wr_addr  = q_cmd.channel[AW-1:0];

    // channel store: zeroed entry by entry after reset
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
            store_mem[clr_idx_reg] <= '0;
        else if (exec && q_cmd.write_ok)
            store_mem[wr_addr] <= q_cmd.level;
        if (exec)
            rd_data_reg <= store_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_idx_reg == AW'(CHANNEL_COUNT - 1))
                clr_busy_reg <= 1'b0;
            else
                clr_idx_reg <= clr_idx_reg + AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_BREAK;
            ticks_left_reg <= RST_BREAK_TICKS;
            byte_index_reg <= '0;
            all_sent_reg   <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            ticks_left_reg <= ticks_left_next;
            byte_index_reg <= byte_index_next;
            all_sent_reg   <= all_sent_next;
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        ticks_left_next = ticks_left_reg;
        byte_index_next = byte_index_reg;
        all_sent_next   = all_sent_reg;
        byte_valid      = 1'b0;
        use_mem         = 1'b0;
        last_byte       = 1'b0;
        if (exec)
        begin
            unique case (q_cmd.op)
                OP_WRITE: ;
                OP_TICK:
                begin
                    if (phase_reg != PH_DATA)
                    begin
                        if (ticks_left_reg > TICK_W'(1))
                            ticks_left_next = ticks_left_reg - TICK_W'(1);
                        else
                        begin
                            unique case (phase_reg)
                                PH_MBB:
                                begin
                                    phase_next      = PH_BREAK;
                                    ticks_left_next = load_len(cfg.break_ticks);
                                end
                                PH_BREAK:
                                begin
                                    phase_next      = PH_MAB;
                                    ticks_left_next = load_len(cfg.mab_ticks);
                                end
                                PH_MAB:
                                begin
                                    phase_next      = PH_DATA;
                                    ticks_left_next = '0;
                                    byte_index_next = '0;
                                    all_sent_next   = 1'b0;
                                end
                                PH_DATA: ;
                            endcase
                        end
                    end
                end
                OP_BYTE_REQ:
                begin
                    if (phase_reg == PH_DATA && !all_sent_reg)
                    begin
                        byte_valid = 1'b1;
                        // index zero is the start code
                        use_mem    = byte_index_reg != '0;
                        if (byte_index_reg >= INDEX_W'(CHANNEL_COUNT))
                        begin
                            last_byte     = 1'b1;
                            all_sent_next = 1'b1;
                        end
                        byte_index_next = byte_index_reg + INDEX_W'(1);
                    end
                end
                OP_TX_DONE:
                begin
                    if (phase_reg == PH_DATA && all_sent_reg)
                    begin
                        phase_next      = PH_MBB;
                        ticks_left_next = load_len(cfg.mbb_ticks);
                        byte_index_next = '0;
                        all_sent_next   = 1'b0;
                    end
                end
            endcase
        end
    end

    // result register: holds one transaction until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (exec)
            res_valid_reg <= 1'b1;
        else if (res.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            res_phase_reg      <= phase_next;
            res_byte_valid_reg <= byte_valid;
            res_use_mem_reg    <= use_mem;
            res_last_reg       <= last_byte;
            res_write_ok_reg   <= q_cmd.write_ok;
        end
    end

    assign res.valid         = res_valid_reg;
    assign res.line_high     = res_phase_reg != PH_BREAK;
    assign res.serializer_on = (res_phase_reg == PH_MAB) || (res_phase_reg == PH_DATA);
    assign res.phase         = res_phase_reg;
    assign res.byte_valid    = res_byte_valid_reg;
    assign res.byte_out      = res_use_mem_reg ? rd_data_reg : '0;
    assign res.last_byte     = res_last_reg;
    assign res.write_ok      = res_write_ok_reg;
endmodule

### sv/dmx_frame_transmitter_unit.sv
// path: an accepted event is written into the command queue and executed from its
// head; its result is registered and held until res.ready takes it
// throughput: one event per cycle while results are taken, set by the phase machine and
// the one read, one write port of the channel store
// reset: control state clears at once; the channel store is then zeroed entry by entry
// with evt.ready low, register writes are taken throughout
//------------------------------------------------------------------------------
// dmx_frame_transmitter_unit
// dmx512 frame sequencer with channel store and apb phase length registers
//------------------------------------------------------------------------------
`include "dmx_frame_transmitter_unit_defines.svh"

module dmx_frame_transmitter_unit #(
    parameter int CHANNEL_COUNT = 512
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dmx_pkg::PADDR_W-1:0] paddr,
    input  logic [dmx_pkg::DATA_W-1:0]  pwdata,
    output logic [dmx_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    dmx_evt_if.sink                     evt,
    dmx_res_if.source                   res
);
    import dmx_pkg::*;

    cfg_t cfg;
    cmd_t push_cmd;
    cmd_t q_cmd;
    logic push;
    logic pop;
    logic q_full;
    logic q_valid;
    logic clear_busy;

    dmx_cfg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dmx_front #(
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_front (
        .clear_busy (clear_busy),
        .q_full     (q_full),
        .evt        (evt),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    dmx_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    dmx_back #(
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .q_valid    (q_valid),
        .q_cmd      (q_cmd),
        .pop        (pop),
        .clear_busy (clear_busy),
        .res        (res)
    );

    // nothing executes or comes out while the store is being zeroed
    `DMX_ASSERT_IMP(a_clear_quiet, clk, rst_n, clear_busy, !res.valid && !pop)
    `DMX_ASSERT_IMP(a_last_in_data, clk, rst_n, res.valid && res.last_byte,
                    res.byte_valid && res.phase == PH_DATA)
    `DMX_ASSERT_IMP(a_idle_byte_zero, clk, rst_n, res.valid && !res.byte_valid,
                    res.byte_out == '0 && !res.last_byte)
    `DMX_ASSERT_NEXT(a_push_queued, clk, rst_n, push, q_valid)
endmodule

### sim/tb.sv
//------------------------------------------------------------------------------
// tb
// regression bench for the dmx frame transmitter: each event is scored against
// its typed table entry, or else against a cycle-free model of the frame
// sequencer and its channel store. A short table of directed events runs first,
// then well-formed frames with random content and noise, under random idling
// on both channels and several phase length settings written over apb.
//------------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import dmx_pkg::*;

    localparam int CHAN_COUNT    = 512;
    localparam int ITEM_TARGET   = 1600;
    localparam int IDLE_LIMIT    = 5000;
    localparam int HOLD_CYCLES   = 500;
    localparam int HOLD_AFTER    = 400;
    localparam int DRAIN_CYCLES  = 8;
    localparam int MAX_REPORTS   = 10;
    localparam int DIR_ROWS      = 16;

    typedef struct packed {
        logic   line_high;
        logic   serializer_on;
        phase_t phase;
        logic   byte_valid;
        logic [LEVEL_W-1:0] byte_out;
        logic   last_byte;
        logic   write_ok;
    } line_state_t;

    typedef struct packed {
        op_t                op;
        logic [CHAN_W-1:0]  chan;
        logic [LEVEL_W-1:0] lvl;
        bit                 typed;
        line_state_t        want;
    } event_row_t;

    localparam line_state_t BREAK_STORED = '{line_high: 1'b0, serializer_on: 1'b0,
        phase: PH_BREAK, byte_valid: 1'b0, byte_out: 8'h00, last_byte: 1'b0,
        write_ok: 1'b1};
    localparam line_state_t BREAK_QUIET = '{line_high: 1'b0, serializer_on: 1'b0,
        phase: PH_BREAK, byte_valid: 1'b0, byte_out: 8'h00, last_byte: 1'b0,
        write_ok: 1'b0};
    localparam line_state_t UNTYPED = '0;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    dmx_evt_if evt_bus ();
    dmx_res_if res_bus ();

    dmx_frame_transmitter_unit #(
        .CHANNEL_COUNT (CHAN_COUNT)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .evt     (evt_bus),
        .res     (res_bus)
    );

    always #5 clk = ~clk;

    // sequencer mirror
    logic [LEVEL_W-1:0] level_mirror [CHAN_COUNT];
    cfg_t               len_cfg;
    phase_t             cur_phase;
    logic [TICK_W-1:0]  ticks_left;
    logic [INDEX_W-1:0] byte_idx;
    bit                 frame_done;

    line_state_t pending_line_states [$];
    int n_events_sent  = 0;
    int n_results_seen = 0;
    int n_errors       = 0;
    int n_stim         = 0;
    int quiet_run      = 0;
    int idle_cycles    = 0;

    function automatic logic [TICK_W-1:0] eff_len(input logic [TICK_W-1:0] v);
        return (v == '0) ? 16'd1 : v;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic predict_line_state(input op_t op, input logic [CHAN_W-1:0] ch,
                                      input logic [LEVEL_W-1:0] lvl,
                                      output line_state_t st);
        st = '0;
        case (op)
            OP_WRITE:
            begin
                // channel field cannot exceed 511, so with 512 channels every write lands
                if (int'(ch) < CHAN_COUNT)
                begin
                    level_mirror[ch] = lvl;
                    st.write_ok = 1'b1;
                end
            end
            OP_TICK:
            begin
                if (cur_phase != PH_DATA)
                begin
                    if (ticks_left > 16'd1)
                        ticks_left = ticks_left - 16'd1;
                    else if (cur_phase == PH_MBB)
                    begin
                        cur_phase  = PH_BREAK;
                        ticks_left = eff_len(len_cfg.break_ticks);
                    end
                    else if (cur_phase == PH_BREAK)
                    begin
                        cur_phase  = PH_MAB;
                        ticks_left = eff_len(len_cfg.mab_ticks);
                    end
                    else
                    begin
                        cur_phase  = PH_DATA;
                        ticks_left = '0;
                        byte_idx   = '0;
                        frame_done = 1'b0;
                    end
                end
            end
            OP_BYTE_REQ:
            begin
                if (cur_phase == PH_DATA && !frame_done)
                begin
                    st.byte_valid = 1'b1;
                    // index zero is the start code
                    if (byte_idx != '0)
                        st.byte_out = level_mirror[CHAN_W'(byte_idx - 10'd1)];
                    if (int'(byte_idx) >= CHAN_COUNT)
                    begin
                        st.last_byte = 1'b1;
                        frame_done   = 1'b1;
                    end
                    byte_idx = byte_idx + 1'b1;
                end
            end
            default:
            begin
                if (cur_phase == PH_DATA && frame_done)
                begin
                    cur_phase  = PH_MBB;
                    ticks_left = eff_len(len_cfg.mbb_ticks);
                    byte_idx   = '0;
                    frame_done = 1'b0;
                end
            end
        endcase
        st.line_high     = (cur_phase != PH_BREAK);
        st.serializer_on = (cur_phase == PH_MAB || cur_phase == PH_DATA);
        st.phase         = cur_phase;
    endtask

    task automatic send_event(input op_t op, input logic [CHAN_W-1:0] ch,
                              input logic [LEVEL_W-1:0] lvl, input bit typed,
                              input line_state_t want);
        line_state_t pred;
        int g;
        evt_bus.valid   <= 1'b1;
        evt_bus.op      <= op;
        evt_bus.channel <= ch;
        evt_bus.level   <= lvl;
        @(posedge clk);
        while (!evt_bus.ready)
            @(posedge clk);
        predict_line_state(op, ch, lvl, pred);
        pending_line_states.push_back(typed ? want : pred);
        n_events_sent++;
        if (quiet_run > 0)
        begin
            quiet_run--;
            g = 0;
        end
        else
        begin
            if ($urandom_range(0, 99) == 0)
                quiet_run = $urandom_range(30, 120);
            g = pick_gap();
        end
        if (g > 0)
        begin
            evt_bus.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic send(input op_t op);
        send_event(op, CHAN_W'($urandom), LEVEL_W'($urandom), 1'b0, UNTYPED);
    endtask

    task automatic drain();
        evt_bus.valid <= 1'b0;
        while (n_results_seen != n_events_sent)
            @(posedge clk);
    endtask

    task automatic cfg_write(input reg_idx_t idx, input logic [TICK_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0000, v};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        // read back through a second transfer
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[TICK_W-1:0] !== v)
        begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
                $display("register %s readback: expected %h got %h",
                         idx.name(), v, prdata[TICK_W-1:0]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_BREAK: len_cfg.break_ticks = v;
            REG_MAB:   len_cfg.mab_ticks   = v;
            default:   len_cfg.mbb_ticks   = v;
        endcase
    endtask

    task automatic maybe_noise(input bit in_data);
        int r;
        if ($urandom_range(0, 4) == 0)
        begin
            r = $urandom_range(0, 9);
            if (r < 6)
            begin
                send(OP_WRITE);
                n_stim++;
            end
            else if (r < 8)
                send(in_data ? OP_TICK : OP_BYTE_REQ);
            else
                send(OP_TX_DONE);
        end
    endtask

    task automatic timed_phase(input int n);
        for (int i = 0; i < n; i++)
        begin
            maybe_noise(1'b0);
            send(OP_TICK);
            n_stim++;
        end
    endtask

    task automatic data_phase();
        for (int i = 0; i <= CHAN_COUNT; i++)
        begin
            maybe_noise(1'b1);
            send(OP_BYTE_REQ);
            n_stim++;
        end
        // request after the last byte is refused
        if ($urandom_range(0, 2) == 0)
            send(OP_BYTE_REQ);
        send(OP_TX_DONE);
        n_stim++;
    endtask

    // result scoreboard
    always @(posedge clk)
    begin
        line_state_t got;
        line_state_t want;
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            got = '{res_bus.line_high, res_bus.serializer_on, phase_t'(res_bus.phase),
                    res_bus.byte_valid, res_bus.byte_out, res_bus.last_byte,
                    res_bus.write_ok};
            if (pending_line_states.size() == 0)
            begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("unexpected result: line=%b ser=%b phase=%0d bv=%b byte=%h"
                             , got.line_high, got.serializer_on, got.phase,
                             got.byte_valid, got.byte_out);
            end
            else
            begin
                want = pending_line_states.pop_front();
                if (got !== want)
                begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                    begin
                        $display("result %0d: expected line=%b ser=%b phase=%0d %s",
                                 n_results_seen, want.line_high, want.serializer_on,
                                 want.phase, "");
                        $display("    expected bv=%b byte=%h last=%b wok=%b",
                                 want.byte_valid, want.byte_out, want.last_byte,
                                 want.write_ok);
                        $display("    got line=%b ser=%b phase=%0d bv=%b byte=%h",
                                 got.line_high, got.serializer_on, got.phase,
                                 got.byte_valid, got.byte_out);
                        $display("    got last=%b wok=%b", got.last_byte, got.write_ok);
                    end
                end
            end
            n_results_seen++;
        end
    end

    // watchdog on transactions of either channel
    always @(posedge clk)
    begin
        if ((evt_bus.valid && evt_bus.ready) || (res_bus.valid && res_bus.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // result side: random stalls plus one long hold-off to back up the event channel
    initial
    begin
        int  cnt;
        bit  hi;
        bit  held;
        held = 1'b0;
        res_bus.ready <= 1'b0;
        forever
        begin
            if (!held && n_events_sent >= HOLD_AFTER)
            begin
                held = 1'b1;
                hi   = 1'b0;
                cnt  = HOLD_CYCLES;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                hi  = 1'b0;
                cnt = 1 + pick_gap();
            end
            else
            begin
                hi  = 1'b1;
                cnt = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 200)
                                                   : $urandom_range(1, 8);
            end
            res_bus.ready <= hi;
            repeat (cnt) @(posedge clk);
        end
    end

    initial
    begin
        event_row_t        dir_rows [DIR_ROWS];
        logic [TICK_W-1:0] brk_left;
        int                frame;

        rst_n           <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        evt_bus.valid   <= 1'b0;
        evt_bus.op      <= OP_WRITE;
        evt_bus.channel <= '0;
        evt_bus.level   <= '0;

        for (int i = 0; i < CHAN_COUNT; i++)
            level_mirror[i] = '0;
        len_cfg    = '{RST_BREAK_TICKS, RST_MAB_TICKS, RST_MBB_TICKS};
        cur_phase  = PH_BREAK;
        ticks_left = RST_BREAK_TICKS;
        byte_idx   = '0;
        frame_done = 1'b0;

        dir_rows = '{
            '{OP_WRITE,    9'd0,   8'hFF, 1'b1, BREAK_STORED},
            '{OP_WRITE,    9'd511, 8'hFF, 1'b1, BREAK_STORED},
            '{OP_WRITE,    9'h155, 8'h55, 1'b1, BREAK_STORED},
            '{OP_WRITE,    9'h0AA, 8'hAA, 1'b1, BREAK_STORED},
            '{OP_WRITE,    9'd1,   8'h00, 1'b1, BREAK_STORED},
            '{OP_BYTE_REQ, 9'd0,   8'h00, 1'b1, BREAK_QUIET},
            '{OP_TX_DONE,  9'd0,   8'h00, 1'b1, BREAK_QUIET},
            '{OP_TICK,     9'd0,   8'h00, 1'b1, BREAK_QUIET},
            '{OP_BYTE_REQ, 9'd511, 8'hFF, 1'b1, BREAK_QUIET},
            '{OP_TX_DONE,  9'd511, 8'hFF, 1'b1, BREAK_QUIET},
            '{OP_TICK,     9'd511, 8'hFF, 1'b1, BREAK_QUIET},
            '{OP_WRITE,    9'd0,   8'h7E, 1'b1, BREAK_STORED},
            '{OP_WRITE,    9'd510, 8'h01, 1'b0, UNTYPED},
            '{OP_WRITE,    9'd2,   8'h80, 1'b0, UNTYPED},
            '{OP_TICK,     9'd0,   8'h00, 1'b0, UNTYPED},
            '{OP_WRITE,    9'd256, 8'h3C, 1'b0, UNTYPED}
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        brk_left = RST_BREAK_TICKS;
        foreach (dir_rows[i])
        begin
            send_event(dir_rows[i].op, dir_rows[i].chan, dir_rows[i].lvl,
                       dir_rows[i].typed, dir_rows[i].want);
            if (dir_rows[i].op == OP_TICK)
                brk_left = brk_left - 16'd1;
        end

        // each frame starts in break with its length already loaded
        frame = 0;
        while (frame < 3 || n_stim < ITEM_TARGET)
        begin
            if (frame > 0)
            begin
                drain();
                if (frame == 2)
                begin
                    // maximum lengths stored, replaced before any of them loads
                    cfg_write(REG_BREAK, 16'hFFFF);
                    cfg_write(REG_MAB, 16'hFFFF);
                    cfg_write(REG_MBB, 16'hFFFF);
                end
                case (frame)
                    1:
                    begin
                        cfg_write(REG_BREAK, 16'd0);
                        cfg_write(REG_MAB, 16'd0);
                        cfg_write(REG_MBB, 16'd0);
                    end
                    default:
                    begin
                        cfg_write(REG_BREAK, 16'($urandom_range(0, 24)));
                        cfg_write(REG_MAB, 16'($urandom_range(0, 24)));
                        cfg_write(REG_MBB, 16'($urandom_range(0, 24)));
                    end
                endcase
            end
            timed_phase(int'(brk_left));
            timed_phase(int'(eff_len(len_cfg.mab_ticks)));
            data_phase();
            timed_phase(int'(eff_len(len_cfg.mbb_ticks)));
            brk_left = eff_len(len_cfg.break_ticks);
            frame++;
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (n_errors == 0 && pending_line_states.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
